[rtl/core/p2d_pkg.sv]
// Shared types, codes and sizing constants of the 2-D pooling unit.
package p2d_pkg;

    // Default storage limits handed to the top-level parameters
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int MAX_KERNEL_DEF = 16;

    // Field widths fixed by the interface
    localparam int VAL_W  = 16;   // Q8.8 sample
    localparam int IDX_W  = 13;   // signed linear index
    localparam int POS_W  = 6;    // row and column fields
    localparam int CFG_W  = 7;    // widest configuration register
    localparam int CFGA_W = 3;    // configuration register index
    localparam int COORD_W = 13;  // signed window coordinate arithmetic

    // Request kinds carried on tuser
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_MAX   = 2'd1,
        FUNC_MEAN  = 2'd2
    } t_func;

    // Configuration register indexes
    localparam logic [CFGA_W-1:0] REG_PLANE_ROWS  = 3'd0;
    localparam logic [CFGA_W-1:0] REG_PLANE_COLS  = 3'd1;
    localparam logic [CFGA_W-1:0] REG_KERNEL_ROWS = 3'd2;
    localparam logic [CFGA_W-1:0] REG_KERNEL_COLS = 3'd3;
    localparam logic [CFGA_W-1:0] REG_STRIDE_ROWS = 3'd4;
    localparam logic [CFGA_W-1:0] REG_STRIDE_COLS = 3'd5;
    localparam logic [CFGA_W-1:0] REG_PAD_ROWS    = 3'd6;
    localparam logic [CFGA_W-1:0] REG_PAD_COLS    = 3'd7;

    // Window sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_BOUNDS,
        ST_PREP,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_DONE
    } t_state;

endpackage

[rtl/core/p2d_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module p2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/p2d_div.sv]
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle.
module p2d_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 10,
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    // Take the magnitude of the dividend and form one restoring step
    always_comb begin
        num_mag = i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;
        rem_sh  = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        fits    = (rem_sh >= {1'b0, r_den});
    end

    // Control: load on start, count down the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend bits in, quotient bits out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= num_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(~r_quo + 1'b1) : $signed(r_quo);

endmodule

[rtl/core/pool2d_window_max_mean_unit.sv]
// Top level of the 2-D max and average pooling unit over one stored plane.
// Set the plane size, kernel, stride and padding on the configuration port
// (i_cfg_we, i_cfg_addr, i_cfg_data) while the unit is idle. Requests enter on
// s_axis; tuser carries the kind (write pixel, max pool, mean pool). A write
// stores one Q8.8 pixel in its accept cycle and gives no result; writes can
// follow back to back. A pool request reads the clipped window from the plane
// memory one pixel per cycle and returns one result on m_axis: the maximum and
// its linear index, or the mean with index -1.
// After accept the sequencer passes setup, bounds and prep, scans the window
// clipped to the plane (at most MAX_KERNEL squared pixels) and drains the last
// read; a mean then runs the bit-serial divider of width SUM_W (24 by default).
// A window with no pixel on the plane skips the scan, and a mean then divides
// only with a positive divisor. The single memory read port sets the scan rate.
// One request is processed at a time; s_axis_tready is high while the sequencer
// is idle, so the next request can be taken in the cycle after the load.
// Reset restores the register defaults and empties the output register; the
// plane memory is not cleared and must be written before it is read.
// A finished result waits in the output register while m_axis_tready is low;
// further requests are still accepted and the next result holds until the
// register frees.
module pool2d_window_max_mean_unit #(
    parameter int MAX_ROWS   = p2d_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = p2d_pkg::MAX_COLS_DEF,
    parameter int MAX_KERNEL = p2d_pkg::MAX_KERNEL_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port
    input  logic                         i_cfg_we,
    input  logic [p2d_pkg::CFGA_W-1:0]   i_cfg_addr,
    input  logic [p2d_pkg::CFG_W-1:0]    i_cfg_data,
    // Request channel
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [5:0] pix_row, [11:6] pix_col, [27:12] pix_value, [33:28] out_row,
    // [39:34] out_col
    input  logic [39:0]                  s_axis_tdata,
    // [1:0] func
    input  logic [1:0]                   s_axis_tuser,
    // Result channel
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] pooled_value, [28:16] max_index, [31:29] zero
    output logic [31:0]                  m_axis_tdata
);

    import p2d_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int SZW   = 2 * KW;
    localparam int SUM_W = VAL_W + $clog2(MAX_KERNEL * MAX_KERNEL);
    localparam int CW    = COORD_W;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] Q_HI    = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] Q_LO    = SUM_W'(-32768);

    // Configuration registers
    logic [6:0] r_plane_rows, r_plane_cols;
    logic [4:0] r_kernel_rows, r_kernel_cols, r_stride_rows, r_stride_cols;
    logic [3:0] r_pad_rows, r_pad_cols;

    // Sequencer
    t_state r_state, n_state;
    t_func  r_func;
    logic [POS_W-1:0] r_out_row, r_out_col;

    // Window geometry
    logic signed [CW-1:0] r_r0, r_c0;
    logic signed [CW-1:0] r_hs, r_he, r_ws, r_we, r_dr, r_dc;
    logic signed [CW-1:0] r_h, r_w;
    logic [AW-1:0]        r_row_addr;
    logic [IDX_W-1:0]     r_row_idx;
    logic [SZW-1:0]       r_size;
    logic                 r_size_ok;

    // Read pipeline and accumulators
    logic                    r_rd_vld;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_found;
    logic signed [VAL_W-1:0] r_best;
    logic [IDX_W-1:0]        r_best_idx;
    logic signed [SUM_W-1:0] r_sum;

    // Output register
    logic               r_m_valid;
    logic [VAL_W-1:0]   r_m_value;
    logic [IDX_W-1:0]   r_m_index;

    // Clamped settings
    logic signed [CW-1:0] rows_c, cols_c, kr_c, kc_c, sr_c, sc_c, pr_c, pc_c;

    // Datapath signals
    logic                    in_accept;
    t_func                   in_func;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;
    logic [IDX_W-1:0]        rd_idx;
    logic                    last_col, last_row, scan_empty;
    logic signed [CW-1:0]    hs, he, ws, we, dr, dc;
    logic signed [VAL_W-1:0] rd_val;
    logic                    div_start, div_done;
    logic signed [SUM_W-1:0] div_quot;
    logic signed [SUM_W-1:0] mean_q;
    logic                    out_free, out_load;

    // Clamp the configuration into the ranges the scan relies on
    always_comb begin
        rows_c = (r_plane_rows == '0) ? CW'(1) :
                 ((CW'(r_plane_rows) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(r_plane_rows));
        cols_c = (r_plane_cols == '0) ? CW'(1) :
                 ((CW'(r_plane_cols) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(r_plane_cols));
        kr_c   = (r_kernel_rows == '0) ? CW'(1) :
                 ((CW'(r_kernel_rows) > CW'(MAX_KERNEL)) ? CW'(MAX_KERNEL) : CW'(r_kernel_rows));
        kc_c   = (r_kernel_cols == '0) ? CW'(1) :
                 ((CW'(r_kernel_cols) > CW'(MAX_KERNEL)) ? CW'(MAX_KERNEL) : CW'(r_kernel_cols));
        sr_c   = (r_stride_rows == '0) ? CW'(1) : CW'(r_stride_rows);
        sc_c   = (r_stride_cols == '0) ? CW'(1) : CW'(r_stride_cols);
        pr_c   = CW'(r_pad_rows);
        pc_c   = CW'(r_pad_cols);
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_rows  <= 7'd64;
            r_plane_cols  <= 7'd64;
            r_kernel_rows <= 5'd2;
            r_kernel_cols <= 5'd2;
            r_stride_rows <= 5'd2;
            r_stride_cols <= 5'd2;
            r_pad_rows    <= 4'd0;
            r_pad_cols    <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PLANE_ROWS:  r_plane_rows  <= i_cfg_data;
                REG_PLANE_COLS:  r_plane_cols  <= i_cfg_data;
                REG_KERNEL_ROWS: r_kernel_rows <= i_cfg_data[4:0];
                REG_KERNEL_COLS: r_kernel_cols <= i_cfg_data[4:0];
                REG_STRIDE_ROWS: r_stride_rows <= i_cfg_data[4:0];
                REG_STRIDE_COLS: r_stride_cols <= i_cfg_data[4:0];
                REG_PAD_ROWS:    r_pad_rows    <= i_cfg_data[3:0];
                REG_PAD_COLS:    r_pad_cols    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Request decode and pixel write path
    always_comb begin
        in_accept = s_axis_tvalid && s_axis_tready;
        in_func   = t_func'(s_axis_tuser);
        ram_we    = in_accept && (in_func == FUNC_WRITE)
                    && (int'(s_axis_tdata[5:0]) < MAX_ROWS)
                    && (int'(s_axis_tdata[11:6]) < MAX_COLS);
        ram_waddr = AW'(AW'(s_axis_tdata[5:0]) * AW'(MAX_COLS)) + AW'(s_axis_tdata[11:6]);
    end

    p2d_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_plane (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (s_axis_tdata[27:12]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Window bounds from the registered corner
    always_comb begin
        hs = (r_r0 < 0) ? CW'(0) : r_r0;
        he = ((r_r0 + kr_c) < rows_c) ? (r_r0 + kr_c) : rows_c;
        ws = (r_c0 < 0) ? CW'(0) : r_c0;
        we = ((r_c0 + kc_c) < cols_c) ? (r_c0 + kc_c) : cols_c;
        dr = (kr_c < (rows_c + pr_c - r_r0)) ? kr_c : (rows_c + pr_c - r_r0);
        dc = (kc_c < (cols_c + pc_c - r_c0)) ? kc_c : (cols_c + pc_c - r_c0);
        scan_empty = (r_hs >= r_he) || (r_ws >= r_we);
    end

    // Scan addressing
    always_comb begin
        ram_raddr = r_row_addr + AW'(r_w);
        rd_idx    = r_row_idx + IDX_W'(r_w);
        last_col  = (r_w == (r_we - CW'(1)));
        last_row  = (r_h == (r_he - CW'(1)));
        rd_val    = $signed(ram_rdata);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (in_func == FUNC_MAX || in_func == FUNC_MEAN)) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP:  n_state = ST_BOUNDS;
            ST_BOUNDS: n_state = ST_PREP;
            ST_PREP: begin
                if (!scan_empty) begin
                    n_state = ST_SCAN;
                end else if (r_func == FUNC_MEAN && (dr > 0) && (dc > 0)) begin
                    n_state = ST_DIVGO;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (last_col && last_row) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = (r_func == FUNC_MEAN && r_size_ok) ? ST_DIVGO : ST_DONE;
            end
            ST_DIVGO: n_state = ST_DIVWAIT;
            ST_DIVWAIT: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        div_start     = (r_state == ST_DIVGO);
        out_free      = !r_m_valid || m_axis_tready;
        out_load      = (r_state == ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the request and walk the window
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_func    <= in_func;
                    r_out_row <= s_axis_tdata[33:28];
                    r_out_col <= s_axis_tdata[39:34];
                end
            end
            ST_SETUP: begin
                r_r0 <= CW'(CW'(r_out_row) * sr_c) - pr_c;
                r_c0 <= CW'(CW'(r_out_col) * sc_c) - pc_c;
            end
            ST_BOUNDS: begin
                r_hs <= hs;
                r_he <= he;
                r_ws <= ws;
                r_we <= we;
                r_dr <= dr;
                r_dc <= dc;
            end
            ST_PREP: begin
                r_h        <= r_hs;
                r_w        <= r_ws;
                r_row_addr <= AW'(AW'(r_hs) * AW'(MAX_COLS));
                r_row_idx  <= IDX_W'(IDX_W'(r_hs) * IDX_W'(cols_c));
                r_size     <= SZW'(SZW'(r_dr) * SZW'(r_dc));
                r_size_ok  <= (r_dr > 0) && (r_dc > 0);
            end
            ST_SCAN: begin
                if (last_col) begin
                    r_w        <= r_ws;
                    r_h        <= r_h + CW'(1);
                    r_row_addr <= r_row_addr + AW'(MAX_COLS);
                    r_row_idx  <= r_row_idx + IDX_W'(cols_c);
                end else begin
                    r_w <= r_w + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // Track reads in flight through the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_SCAN);
        end
        r_rd_idx <= rd_idx;
    end

    // Accumulate max and sum as pixels return
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_found    <= 1'b0;
            r_best     <= VAL_MIN;
            r_best_idx <= '1;
            r_sum      <= '0;
        end else if (r_rd_vld) begin
            if (!r_found || rd_val > r_best) begin
                r_found    <= 1'b1;
                r_best     <= rd_val;
                r_best_idx <= r_rd_idx;
            end
            r_sum <= r_sum + SUM_W'(rd_val);
        end
    end

    p2d_div #(
        .NUM_W (SUM_W),
        .DEN_W (SZW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum),
        .i_den   (r_size),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Saturate the mean to the sample range
    always_comb begin
        if (!r_size_ok) begin
            mean_q = '0;
        end else if (div_quot > Q_HI) begin
            mean_q = Q_HI;
        end else if (div_quot < Q_LO) begin
            mean_q = Q_LO;
        end else begin
            mean_q = div_quot;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_func == FUNC_MEAN) begin
                r_m_value <= mean_q[VAL_W-1:0];
                r_m_index <= '1;
            end else begin
                r_m_value <= r_best;
                r_m_index <= r_best_idx;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_index, r_m_value};

`ifndef ASSERT_OFF
    // Memory data is consumed only for addresses issued by the scan
    a_rd_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == ST_SCAN))
        else $error("read data accepted without a scan address");

    // A new result appears only from the completion state
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside completion");

    // No pixel write lands while a window is being evaluated
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !ram_we)
        else $error("plane write during window evaluation");

    // Divider runs only after the scan pipeline has drained
    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVWAIT) |-> (!r_rd_vld && r_func == FUNC_MEAN))
        else $error("divider active with reads pending or wrong request");
`endif

endmodule

[sim/testbench.sv]
// Self-checking testbench of the 2-D max and mean pooling unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import p2d_pkg::*;

    // Unused request kind: accepted and dropped without a result
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // Longest pool request (mean over a full kernel) plus margin
    localparam int SETTLE_CYCLES = 7 + MAX_KERNEL_DEF * MAX_KERNEL_DEF + 24 + 40;
    localparam int ITEMS_PER_PHASE = 115;

    typedef struct packed {
        logic [5:0]  out_col;
        logic [5:0]  out_row;
        logic [15:0] pix_value;
        logic [5:0]  pix_col;
        logic [5:0]  pix_row;
    } t_pool_req;

    typedef struct packed {
        logic [1:0] func;
        t_pool_req  data;
    } t_req_item;

    typedef struct packed {
        logic [2:0]  pad;
        logic [12:0] index;
        logic [15:0] value;
    } t_pool_result;

    // Window geometry under the current register settings
    typedef struct {
        int rows, cols, kr, kc, sr, sc, pr, pc;
        int top, left, row_lo, row_hi, col_lo, col_hi;
    } t_window;

    typedef enum {PACE_FREE, PACE_SENDER_IDLE, PACE_SINK_STALL, PACE_BOTH} t_pace;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_addr    = '0;
    logic [6:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // Register copies, reset values
    logic [6:0] cfg_plane_rows  = 7'd64;
    logic [6:0] cfg_plane_cols  = 7'd64;
    logic [4:0] cfg_kernel_rows = 5'd2;
    logic [4:0] cfg_kernel_cols = 5'd2;
    logic [4:0] cfg_stride_rows = 5'd2;
    logic [4:0] cfg_stride_cols = 5'd2;
    logic [3:0] cfg_pad_rows    = 4'd0;
    logic [3:0] cfg_pad_cols    = 4'd0;

    shortint      plane_model [MAX_ROWS_DEF*MAX_COLS_DEF];
    bit           pix_loaded  [MAX_ROWS_DEF*MAX_COLS_DEF];
    t_req_item    pending_req_q [$];
    t_pool_result expected_pool_q [$];
    t_req_item    drv_req = '0;
    bit           req_fire = 1'b0;
    int           sender_idle_pct = 0;
    int           sink_stall_pct = 0;
    int           mismatch_count = 0;
    int           queued_count = 0;

    pool2d_window_max_mean_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int min_int(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int max_int(int a, int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        return min_int(max_int(v, lo), hi);
    endfunction

    // Saturate the registers and clip the window to the plane
    function automatic t_window place_window(int orow, int ocol);
        t_window win;
        win.rows   = clamp_int(int'(cfg_plane_rows), 1, MAX_ROWS_DEF);
        win.cols   = clamp_int(int'(cfg_plane_cols), 1, MAX_COLS_DEF);
        win.kr     = clamp_int(int'(cfg_kernel_rows), 1, MAX_KERNEL_DEF);
        win.kc     = clamp_int(int'(cfg_kernel_cols), 1, MAX_KERNEL_DEF);
        win.sr     = max_int(int'(cfg_stride_rows), 1);
        win.sc     = max_int(int'(cfg_stride_cols), 1);
        win.pr     = int'(cfg_pad_rows);
        win.pc     = int'(cfg_pad_cols);
        win.top    = orow * win.sr - win.pr;
        win.left   = ocol * win.sc - win.pc;
        win.row_lo = max_int(win.top, 0);
        win.row_hi = min_int(win.top + win.kr, win.rows);
        win.col_lo = max_int(win.left, 0);
        win.col_hi = min_int(win.left + win.kc, win.cols);
        return win;
    endfunction

    // Max or mean of one window over the plane copy
    function automatic t_pool_result predict_pool(logic [1:0] func, int orow, int ocol);
        t_window      win;
        t_pool_result res;
        bit           found;
        int           sample, best, best_idx, sum, size, quot;
        win = place_window(orow, ocol);
        res.pad = '0;
        if (func == FUNC_MAX) begin
            found    = 1'b0;
            best     = -32768;
            best_idx = -1;
            // Strict compare keeps the first pixel in raster order on ties
            for (int h = win.row_lo; h < win.row_hi; h++) begin
                for (int w = win.col_lo; w < win.col_hi; w++) begin
                    sample = int'(plane_model[h*MAX_COLS_DEF + w]);
                    if (!found || sample > best) begin
                        found    = 1'b1;
                        best     = sample;
                        best_idx = h * win.cols + w;
                    end
                end
            end
            res.value = best[15:0];
            res.index = best_idx[12:0];
        end else begin
            // Divisor counts padding; it may be zero or negative off the plane
            size = (min_int(win.top + win.kr, win.rows + win.pr) - win.top) *
                   (min_int(win.left + win.kc, win.cols + win.pc) - win.left);
            sum = 0;
            for (int h = win.row_lo; h < win.row_hi; h++)
                for (int w = win.col_lo; w < win.col_hi; w++)
                    sum += int'(plane_model[h*MAX_COLS_DEF + w]);
            quot = (size <= 0) ? 0 : clamp_int(sum / size, -32768, 32767);
            res.value = quot[15:0];
            res.index = '1;
        end
        return res;
    endfunction

    // Update the plane copy or queue the expected result of one request
    function automatic void apply_request(t_req_item req);
        case (req.func)
            FUNC_WRITE:
                plane_model[req.data.pix_row*MAX_COLS_DEF + req.data.pix_col] = req.data.pix_value;
            FUNC_MAX, FUNC_MEAN:
                expected_pool_q.push_back(predict_pool(req.func, int'(req.data.out_row),
                                                       int'(req.data.out_col)));
            default: ;
        endcase
    endfunction

    // Drive requests and sink backpressure on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_fire) begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                drv_req = pending_req_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= drv_req.data;
                s_axis_tuser  <= drv_req.func;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check results, then record the request accepted at this edge
    always @(posedge i_clk) begin : result_monitor
        t_pool_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_pool_q.size() == 0) begin
                $error("unexpected result: pooled_value %0d, max_index %0d",
                       $signed(got.value), $signed(got.index));
                mismatch_count++;
            end else begin
                want = expected_pool_q.pop_front();
                if (got.value !== want.value) begin
                    $error("pooled_value mismatch: expected %0d, got %0d",
                           $signed(want.value), $signed(got.value));
                    mismatch_count++;
                end
                if (got.index !== want.index) begin
                    $error("max_index mismatch: expected %0d, got %0d",
                           $signed(want.index), $signed(got.index));
                    mismatch_count++;
                end
                if (got.pad !== want.pad) begin
                    $error("zero fill mismatch: expected %0d, got %0d", want.pad, got.pad);
                    mismatch_count++;
                end
            end
        end
        req_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (req_fire)
            apply_request(drv_req);
    end

    function automatic t_pool_req random_fields();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[39:0];
    endfunction

    // Favor a few extreme values so ties and saturation show up
    function automatic logic [15:0] random_sample();
        if ($urandom_range(3) != 0)
            return 16'($urandom);
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'h0100;
        endcase
    endfunction

    task automatic queue_write(int row, int col, logic [15:0] value);
        t_req_item item;
        item.func           = FUNC_WRITE;
        item.data           = random_fields();
        item.data.pix_row   = 6'(row);
        item.data.pix_col   = 6'(col);
        item.data.pix_value = value;
        pix_loaded[row*MAX_COLS_DEF + col] = 1'b1;
        pending_req_q.push_back(item);
        queued_count++;
    endtask

    task automatic queue_unused();
        t_req_item item;
        item.func = FUNC_UNUSED;
        item.data = random_fields();
        pending_req_q.push_back(item);
    endtask

    // Load every unwritten pixel of the clipped window first, then pool it
    task automatic queue_pool(logic [1:0] func, int orow, int ocol);
        t_req_item item;
        t_window   win;
        win = place_window(orow, ocol);
        for (int h = win.row_lo; h < win.row_hi; h++)
            for (int w = win.col_lo; w < win.col_hi; w++)
                if (!pix_loaded[h*MAX_COLS_DEF + w])
                    queue_write(h, w, random_sample());
        item.func         = func;
        item.data         = random_fields();
        item.data.out_row = 6'(orow);
        item.data.out_col = 6'(ocol);
        pending_req_q.push_back(item);
        queued_count++;
    endtask

    // Mostly windows that touch the padded plane, some anywhere
    task automatic queue_random_pool();
        t_window win;
        int      orow, ocol;
        win = place_window(0, 0);
        if ($urandom_range(99) < 80) begin
            orow = $urandom_range(0, min_int(63, (win.rows + 2*win.pr) / win.sr));
            ocol = $urandom_range(0, min_int(63, (win.cols + 2*win.pc) / win.sc));
        end else begin
            orow = $urandom_range(0, 63);
            ocol = $urandom_range(0, 63);
        end
        queue_pool($urandom_range(1) ? FUNC_MAX : FUNC_MEAN, orow, ocol);
    endtask

    // Wait until every request is taken and every result has come back
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #0.1;
        end while (pending_req_q.size() != 0 || expected_pool_q.size() != 0 ||
                   (s_axis_tvalid && !req_fire));
    endtask

    task automatic write_reg(logic [2:0] addr, logic [6:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        case (addr)
            REG_PLANE_ROWS:  cfg_plane_rows  = data;
            REG_PLANE_COLS:  cfg_plane_cols  = data;
            REG_KERNEL_ROWS: cfg_kernel_rows = data[4:0];
            REG_KERNEL_COLS: cfg_kernel_cols = data[4:0];
            REG_STRIDE_ROWS: cfg_stride_rows = data[4:0];
            REG_STRIDE_COLS: cfg_stride_cols = data[4:0];
            REG_PAD_ROWS:    cfg_pad_rows    = data[3:0];
            REG_PAD_COLS:    cfg_pad_cols    = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_pace(t_pace mode);
        case (mode)
            PACE_FREE:        begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            PACE_SENDER_IDLE: begin sender_idle_pct = 66; sink_stall_pct = 0;  end
            PACE_SINK_STALL:  begin sender_idle_pct = 0;  sink_stall_pct = 66; end
            default:          begin sender_idle_pct = 29; sink_stall_pct = 29; end
        endcase
    endtask

    // Drain, reprogram all registers, then run a random batch with a
    // full pause halfway through
    task automatic run_phase(int rows, int cols, int kr, int kc, int sr, int sc,
                             int pr, int pc, t_pace mode);
        int start, pick;
        bit paused;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_PLANE_ROWS, 7'(rows));
        write_reg(REG_PLANE_COLS, 7'(cols));
        write_reg(REG_KERNEL_ROWS, 7'(kr));
        write_reg(REG_KERNEL_COLS, 7'(kc));
        write_reg(REG_STRIDE_ROWS, 7'(sr));
        write_reg(REG_STRIDE_COLS, 7'(sc));
        write_reg(REG_PAD_ROWS, 7'(pr));
        write_reg(REG_PAD_COLS, 7'(pc));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        set_pace(mode);
        start  = queued_count;
        paused = 1'b0;
        while (queued_count - start < ITEMS_PER_PHASE) begin
            if (!paused && queued_count - start >= ITEMS_PER_PHASE / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 25)
                queue_write($urandom_range(0, 63), $urandom_range(0, 63), random_sample());
            else if (pick < 29)
                queue_unused();
            else
                queue_random_pool();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed checks under the reset settings: 2x2 kernel, stride 2
        set_pace(PACE_FREE);
        queue_write(0, 0, 16'h7FFF);
        queue_write(0, 1, 16'h8000);
        queue_write(1, 0, 16'h8000);
        queue_write(1, 1, 16'h8000);
        queue_pool(FUNC_MAX, 0, 0);
        queue_pool(FUNC_MEAN, 0, 0);
        // all-minimum window still reports its first pixel
        queue_write(62, 62, 16'h8000);
        queue_write(62, 63, 16'h8000);
        queue_write(63, 62, 16'h8000);
        queue_write(63, 63, 16'h8000);
        queue_pool(FUNC_MAX, 31, 31);
        queue_pool(FUNC_MEAN, 31, 31);
        // tie for the maximum
        queue_write(2, 2, 16'h0100);
        queue_write(2, 3, 16'h0100);
        queue_write(3, 2, 16'h0080);
        queue_write(3, 3, 16'h0100);
        queue_pool(FUNC_MAX, 1, 1);
        queue_pool(FUNC_MEAN, 1, 1);
        // window entirely off the plane
        queue_pool(FUNC_MAX, 63, 63);
        queue_pool(FUNC_MEAN, 63, 63);
        queue_unused();
        // largest index
        queue_write(63, 63, 16'hFFFF);
        queue_pool(FUNC_MAX, 31, 31);

        // Register sweeps, zero and oversized values among them
        run_phase(64, 64, 2, 2, 2, 2, 0, 0, PACE_FREE);
        run_phase(8, 8, 3, 3, 1, 1, 1, 1, PACE_SENDER_IDLE);
        run_phase(0, 0, 0, 0, 0, 0, 0, 0, PACE_SINK_STALL);
        run_phase(127, 127, 127, 127, 127, 127, 127, 127, PACE_BOTH);
        run_phase(16, 16, 16, 16, 1, 1, 0, 0, PACE_FREE);
        run_phase(64, 64, 4, 3, 3, 4, 2, 1, PACE_SENDER_IDLE);
        run_phase(33, 20, 5, 7, 2, 3, 15, 0, PACE_SINK_STALL);
        for (int p = 0; p < 5; p++)
            run_phase($urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 127), $urandom_range(0, 127), t_pace'((p + 3) % 4));

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pool_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
